### design/wcs_pkg.sv
// Package for the wall-centering PD steering block: register codes, FSM state codes,
// fixed-point constants and the quarter-wave sine table built at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package wcs_pkg;

  // sine table over one full turn; a power of two from 64 to 4096
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_W            = IDX_W - 2;
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;

  // angles in tenths of a degree
  localparam int FULL_TURN = 3600;
  localparam int ANGLE_90  = 900;

  // table index = floor(t * depth / 3600) = (t * ANG_MULT) >> ANG_SHIFT, exact for t < 3600
  localparam int    ANG_SHIFT = 24;
  localparam longint ANG_MULT =
    ((longint'(1) << ANG_SHIFT) * SINE_TABLE_DEPTH + FULL_TURN - 1) / FULL_TURN;

  // floor(x / 10) = (x * HD_RECIP) >> HD_SHIFT for 12-bit x
  localparam int HD_RECIP = 3277;
  localparam int HD_SHIFT = 15;
  localparam int HD_W     = 9;

  // duty limit in percent
  localparam int DUTY_MAX = 100;

  // register reset values
  localparam logic [7:0]  RST_GOAL  = 8'd42;
  localparam logic [6:0]  RST_BASE  = 7'd28;
  localparam logic [15:0] RST_KP    = 16'd26;
  localparam logic [15:0] RST_KD    = 16'hFFCD;  // -51
  localparam logic [15:0] RST_KH    = 16'd2560;
  localparam logic [11:0] RST_FRONT = 12'd80;
  localparam logic [11:0] RST_SIDE  = 12'd100;

  // quarter-wave polynomial coefficients, Q30
  localparam longint SIN_C1 = 64'd1686629713;
  localparam longint SIN_C3 = 64'd693598668;
  localparam longint SIN_C5 = 64'd85569306;
  localparam longint SIN_C7 = 64'd5027000;
  localparam longint SIN_C9 = 64'd172271;

  typedef enum logic [2:0] {
    REG_GOAL  = 3'd0,
    REG_BASE  = 3'd1,
    REG_KP    = 3'd2,
    REG_KD    = 3'd3,
    REG_KH    = 3'd4,
    REG_FRONT = 3'd5,
    REG_SIDE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ANGLE = 15'b000000000000010,
    S_CIDX  = 15'b000000000000100,
    S_CRD   = 15'b000000000001000,
    S_HIDX  = 15'b000000000010000,
    S_HRD   = 15'b000000000100000,
    S_HMUL  = 15'b000000001000000,
    S_HEAD  = 15'b000000010000000,
    S_CMUL  = 15'b000000100000000,
    S_ERR   = 15'b000001000000000,
    S_PMUL  = 15'b000010000000000,
    S_DMUL  = 15'b000100000000000,
    S_SUM   = 15'b001000000000000,
    S_DUTY  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  typedef struct packed {
    logic       driving;
    logic [6:0] left_duty;
    logic [6:0] right_duty;
    logic       front_wall;
    logic       right_wall;
    logic       left_wall;
  } result_t;

  typedef logic [15:0] qtab_t [QUARTER];

  // sin(pi/2 * z), z in Q30 on [0,1], rounded to Q15 and limited
  function automatic logic [15:0] quarter_entry(longint z);
    longint z2;
    longint acc;
    longint v;
    z2  = (z * z) >>> 30;
    acc = SIN_C7 - ((z2 * SIN_C9) >>> 30);
    acc = SIN_C5 - ((z2 * acc) >>> 30);
    acc = SIN_C3 - ((z2 * acc) >>> 30);
    acc = SIN_C1 - ((z2 * acc) >>> 30);
    v   = (((z * acc) >>> 30) + 64'd16384) >>> 15;
    if (v > 64'd32767) v = 64'd32767;
    return 16'(v);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int j = 0; j < QUARTER; j++) begin
      t[j] = quarter_entry(longint'(j) << (30 - QTR_W));
    end
    return t;
  endfunction

  localparam qtab_t       QTAB = build_qtab();
  localparam logic [15:0] QTOP = quarter_entry(longint'(1) << 30);  // quarter turn exactly

endpackage

### design/wall_centering_pd_steering.sv
// Wall-centering PD steering: sequencer around one shared signed multiplier,
// sine lookup and per-wheel PD duty. Depends on wcs_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input request: in_valid/in_ready with front, right and left ranges, measured
//   heading (tenths of a degree) and wanted cardinal heading. in_ready is high only
//   while the sequencer is idle; one request is worked on at a time.
//   Output request: out_valid/out_ready with driving, both duties and wall flags,
//   held in an output register. The sequencer goes idle again as soon as the result
//   is loaded there, so the next input can be taken while the result waits.
//   Configuration: cfg_write/cfg_index/cfg_data, written while idle, no read-back.
// Sequence:
//   Front clear: the request passes through the single multiplier, used for the
//   heading divide, two angle-to-index scalings, the heading term and three products
//   per wheel, plus two sine table reads.
//   Front blocked: the sequencer goes from the angle state straight to the done state.
//   If the receiver stalls with a result still held, the next result waits in the
//   done state until the output register frees up.
// Reset (rst, synchronous): registers to their defaults, both stored wheel errors to
//   42 mm in Q.8, sequencer idle, no output valid.
module wall_centering_pd_steering
  import wcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] front_range,
  input  logic [11:0] right_range,
  input  logic [11:0] left_range,
  input  logic [11:0] measured_heading,
  input  logic [1:0]  wanted_heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        driving,
  output logic [6:0]  left_duty,
  output logic [6:0]  right_duty,
  output logic        front_wall,
  output logic        right_wall,
  output logic        left_wall,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [7:0]         goal_distance;
  logic [6:0]         base_duty;
  logic signed [15:0] proportional_gain;
  logic signed [15:0] derivative_gain;
  logic signed [15:0] heading_gain;
  logic [11:0]        front_clear_distance;
  logic [11:0]        side_wall_distance;

  // request capture
  logic [11:0] front_q, right_q, left_q, head_q;
  logic [1:0]  wanted_q;

  state_t state, state_next;
  logic   side;  // 0 right wheel, 1 left wheel

  logic signed [23:0] previous_right_error, previous_left_error;
  logic signed [44:0] prod_q;
  logic signed [15:0] rom_q;
  logic signed [15:0] cos_q;
  logic signed [24:0] head_term;
  logic signed [23:0] e_q;
  logic signed [24:0] d_q;
  logic signed [44:0] acc_q;
  result_t            res_q;
  result_t            out_res;

  // ---------------- combinational datapath ----------------
  logic [11:0] dist_a, ref_ang, diff;
  logic [HD_W-1:0] hd;
  logic [12:0] t_c_raw, t_h_raw, ang_raw;
  logic [11:0] ang;
  logic [IDX_W-1:0] k;
  logic [QTR_W-1:0] j, j_mirror;
  logic [1:0]  quad;
  logic [15:0] mag, rom_val;
  logic        rom_neg;
  logic signed [27:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [44:0] prod;
  logic signed [37:0] rnd7;
  logic signed [28:0] q_part;
  logic signed [29:0] dsum;
  logic [6:0]  duty_pd, base_sat, duty_side;
  logic [11:0] side_range, gap;
  logic        far;
  logic signed [23:0] prev_sel;

  always_comb begin
    case (wanted_q)
      2'd1:    ref_ang = 12'(ANGLE_90);
      2'd2:    ref_ang = 12'(2 * ANGLE_90);
      2'd3:    ref_ang = 12'(3 * ANGLE_90);
      default: ref_ang = 12'(FULL_TURN);
    endcase
    if (head_q > ref_ang) dist_a = head_q - ref_ang;
    else                  dist_a = ref_ang - head_q;
    // heading 0 also measures the short way round through zero
    if (wanted_q == 2'd0 && head_q < dist_a) diff = head_q;
    else                                     diff = dist_a;
  end

  assign hd      = prod_q[HD_SHIFT +: HD_W];
  assign t_c_raw = 13'({hd, 3'b000}) + 13'({hd, 1'b0}) + 13'(ANGLE_90);
  assign t_h_raw = 13'(head_q) + (wanted_q[0] ? 13'(ANGLE_90) : 13'd0);
  assign ang_raw = (state == S_CIDX) ? t_c_raw : t_h_raw;
  assign ang     = (ang_raw >= 13'(FULL_TURN)) ? 12'(ang_raw - 13'(FULL_TURN)) : ang_raw[11:0];

  // sine lookup with quadrant mirroring
  assign k        = prod_q[ANG_SHIFT +: IDX_W];
  assign quad     = k[IDX_W-1 -: 2];
  assign j        = k[QTR_W-1:0];
  assign j_mirror = ~j + QTR_W'(1);
  assign rom_neg  = quad[1] ^ (state == S_HRD && (wanted_q == 2'd1 || wanted_q == 2'd2));

  always_comb begin
    if (!quad[0])       mag = QTAB[j];
    else if (j == '0)   mag = QTOP;
    else                mag = QTAB[j_mirror];
    rom_val = rom_neg ? 16'd0 - mag : mag;
  end

  assign side_range = side ? left_q : right_q;
  assign prev_sel   = side ? previous_left_error : previous_right_error;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_ANGLE: begin
        mul_a = 28'(diff);
        mul_b = 17'(HD_RECIP);
      end
      S_CIDX, S_HIDX: begin
        mul_a = 28'(ANG_MULT);
        mul_b = 17'(ang);
      end
      S_HMUL: begin
        mul_a = 28'(rom_q);
        mul_b = 17'(heading_gain);
      end
      S_CMUL: begin
        mul_a = 28'(cos_q);
        mul_b = 17'(side_range);
      end
      S_PMUL: begin
        mul_a = 28'(e_q);
        mul_b = 17'(proportional_gain);
      end
      S_DMUL: begin
        mul_a = 28'(d_q);
        mul_b = 17'(derivative_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign rnd7 = 38'((prod_q + 45'sd64) >>> 7);

  // duty: truncate toward zero, add base, saturate; far wall keeps base
  always_comb begin
    if (acc_q < 0) q_part = 29'((acc_q + 45'sd65535) >>> 16);
    else           q_part = 29'(acc_q >>> 16);
    dsum = 30'(q_part) + 30'($signed({1'b0, base_duty}));
    if (dsum < 0)                    duty_pd = 7'd0;
    else if (dsum > 30'(DUTY_MAX))   duty_pd = 7'(DUTY_MAX);
    else                             duty_pd = dsum[6:0];
    base_sat = (base_duty > 7'(DUTY_MAX)) ? 7'(DUTY_MAX) : base_duty;
    if (side_range > 12'(goal_distance)) gap = side_range - 12'(goal_distance);
    else                                 gap = 12'(goal_distance) - side_range;
    far       = gap > 12'(goal_distance);
    duty_side = far ? base_sat : duty_pd;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ANGLE;
      S_ANGLE: state_next = (front_q > front_clear_distance) ? S_CIDX : S_DONE;
      S_CIDX:  state_next = S_CRD;
      S_CRD:   state_next = S_HIDX;
      S_HIDX:  state_next = S_HRD;
      S_HRD:   state_next = S_HMUL;
      S_HMUL:  state_next = S_HEAD;
      S_HEAD:  state_next = S_CMUL;
      S_CMUL:  state_next = S_ERR;
      S_ERR:   state_next = S_PMUL;
      S_PMUL:  state_next = S_DMUL;
      S_DMUL:  state_next = S_SUM;
      S_SUM:   state_next = S_DUTY;
      S_DUTY:  state_next = side ? S_DONE : S_CMUL;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      side                 <= 1'b0;
      out_valid            <= 1'b0;
      goal_distance        <= RST_GOAL;
      base_duty            <= RST_BASE;
      proportional_gain    <= RST_KP;
      derivative_gain      <= RST_KD;
      heading_gain         <= RST_KH;
      front_clear_distance <= RST_FRONT;
      side_wall_distance   <= RST_SIDE;
      previous_right_error <= 24'($signed({1'b0, RST_GOAL, 8'h00}));
      previous_left_error  <= 24'($signed({1'b0, RST_GOAL, 8'h00}));
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_GOAL:  goal_distance        <= cfg_data[7:0];
          REG_BASE:  base_duty            <= cfg_data[6:0];
          REG_KP:    proportional_gain    <= cfg_data;
          REG_KD:    derivative_gain      <= cfg_data;
          REG_KH:    heading_gain         <= cfg_data;
          REG_FRONT: front_clear_distance <= cfg_data[11:0];
          REG_SIDE:  side_wall_distance   <= cfg_data[11:0];
          default:   ;
        endcase
      end

      if (state == S_ANGLE) begin
        side <= 1'b0;
        if (front_q <= front_clear_distance) begin
          previous_right_error <= 24'($signed({1'b0, goal_distance, 8'h00}));
          previous_left_error  <= 24'($signed({1'b0, goal_distance, 8'h00}));
        end
      end

      if (state == S_DUTY) begin
        side <= 1'b1;
        if (side) previous_left_error  <= e_q;
        else      previous_right_error <= e_q;
      end

      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready)                               out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_q <= prod;
    rom_q  <= rom_val;
    if (in_valid && in_ready) begin
      front_q  <= front_range;
      right_q  <= right_range;
      left_q   <= left_range;
      head_q   <= measured_heading;
      wanted_q <= wanted_heading;
    end
    unique case (state)
      S_ANGLE: begin
        if (front_q > front_clear_distance) begin
          res_q.driving    <= 1'b1;
          res_q.front_wall <= 1'b0;
          res_q.right_wall <= 1'b0;
          res_q.left_wall  <= 1'b0;
        end else begin
          res_q.driving    <= 1'b0;
          res_q.left_duty  <= 7'd0;
          res_q.right_duty <= 7'd0;
          res_q.front_wall <= 1'b1;
          res_q.right_wall <= right_q < side_wall_distance;
          res_q.left_wall  <= left_q < side_wall_distance;
        end
      end
      S_HIDX: cos_q     <= rom_q;
      S_HEAD: head_term <= 25'(rnd7);
      S_ERR:  e_q       <= 24'($signed({1'b0, goal_distance, 8'h00}) - rnd7);
      S_PMUL: d_q       <= 25'(prev_sel) - 25'(e_q);
      S_DMUL: acc_q     <= side ? prod_q - 45'(head_term) : prod_q + 45'(head_term);
      S_SUM:  acc_q     <= acc_q + prod_q;
      S_DUTY: begin
        if (side) res_q.left_duty  <= duty_side;
        else      res_q.right_duty <= duty_side;
      end
      S_DONE: if (!out_valid || out_ready) out_res <= res_q;
      default: ;
    endcase
  end

  assign driving    = out_res.driving;
  assign left_duty  = out_res.left_duty;
  assign right_duty = out_res.right_duty;
  assign front_wall = out_res.front_wall;
  assign right_wall = out_res.right_wall;
  assign left_wall  = out_res.left_wall;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while sequencer busy");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_duty <= 7'(DUTY_MAX) && right_duty <= 7'(DUTY_MAX))
    else $error("duty above limit");

  a_stop_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !driving |-> front_wall && left_duty == 7'd0 && right_duty == 7'd0)
    else $error("stop result malformed");

  a_drive_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && driving |-> !front_wall && !right_wall && !left_wall)
    else $error("wall flags set while driving");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> state == S_DONE && out_valid)
    else $error("result dropped while output stalled");

endmodule

### bench/testbench.sv
// Self-checking bench for wall_centering_pd_steering: random and directed steering requests,
// a scoreboard class that predicts each result, random stalls on both handshakes.
// Depends on wcs_pkg and the wall_centering_pd_steering RTL.
`timescale 1ns / 1ps

typedef enum logic [1:0] {
  HEAD_0   = 2'd0,
  HEAD_90  = 2'd1,
  HEAD_180 = 2'd2,
  HEAD_270 = 2'd3
} cardinal_t;

typedef struct packed {
  logic [11:0] front;
  logic [11:0] right;
  logic [11:0] left;
  logic [11:0] heading;
  logic [1:0]  wanted;
} steer_request_t;

class steering_scoreboard;
  logic [7:0]         goal;
  logic [6:0]         base;
  logic signed [15:0] kp;
  logic signed [15:0] kd;
  logic signed [15:0] kh;
  logic [11:0]        front_clear;
  logic [11:0]        side_wall;
  longint             prev_right;
  longint             prev_left;
  wcs_pkg::result_t   awaited[$];
  int                 mismatches;
  int                 compared;

  function new();
    goal        = 8'd42;
    base        = 7'd28;
    kp          = 16'sd26;
    kd          = -16'sd51;
    kh          = 16'sd2560;
    front_clear = 12'd80;
    side_wall   = 12'd100;
    prev_right  = 42 * 256;
    prev_left   = 42 * 256;
    mismatches  = 0;
    compared    = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      wcs_pkg::REG_GOAL:  goal = data[7:0];
      wcs_pkg::REG_BASE:  base = data[6:0];
      wcs_pkg::REG_KP:    kp = data;
      wcs_pkg::REG_KD:    kd = data;
      wcs_pkg::REG_KH:    kh = data;
      wcs_pkg::REG_FRONT: front_clear = data[11:0];
      wcs_pkg::REG_SIDE:  side_wall = data[11:0];
      default: ;
    endcase
  endfunction

  // sin(pi/2 * z), z in Q30 on [0, 1], odd polynomial, result Q30
  function longint quarter_wave(longint z);
    longint z2, acc;
    z2  = (z * z) >>> 30;
    acc = 5027000 - ((z2 * 172271) >>> 30);
    acc = 85569306 - ((z2 * acc) >>> 30);
    acc = 693598668 - ((z2 * acc) >>> 30);
    acc = 1686629713 - ((z2 * acc) >>> 30);
    return (z * acc) >>> 30;
  endfunction

  // Q15 sine of an angle in tenths of a degree, as read from the table
  function longint sine_q15(longint tenths);
    longint depth, t, k, q, r, z, v;
    depth = wcs_pkg::SINE_TABLE_DEPTH;
    t = tenths % 3600;
    k = t * depth / 3600;
    if (k >= depth) k = depth - 1;
    q = 4 * k / depth;
    r = 4 * k - q * depth;
    z = (r <<< 30) / depth;
    if (q % 2 == 1) z = (longint'(1) <<< 30) - z;
    v = (quarter_wave(z) + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (q >= 2) v = -v;
    return v;
  endfunction

  // round half up is a floor after adding half
  function longint round_q(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function longint trunc_q(longint x, int n);
    if (x >= 0) return x >>> n;
    return -((-x) >>> n);
  endfunction

  function longint clamp_duty(longint d);
    if (d < 0) return 0;
    if (d > 100) return 100;
    return d;
  endfunction

  function logic [6:0] wheel_duty(longint range, longint cos_hd, longint head,
                                  inout longint prev);
    longint g, b, e, sum, gap, duty;
    g   = goal;
    b   = base;
    e   = (g <<< 8) - round_q(cos_hd * range, 7);
    sum = e * kp + (prev - e) * kd + head;
    gap = g - range;
    if (gap < 0) gap = -gap;
    if (gap > g) duty = clamp_duty(b);
    else duty = clamp_duty(b + trunc_q(sum, 16));
    prev = e;
    return 7'(duty);
  endfunction

  function void note_request(steer_request_t rq);
    wcs_pkg::result_t want;
    longint h, w, a, b, d, hd, cos_hd, term, head;
    want = '0;
    if (rq.front > front_clear) begin
      h = rq.heading;
      w = rq.wanted;
      if (rq.wanted == HEAD_0) begin
        a  = (h > 3600 ? h - 3600 : 3600 - h) / 10;
        b  = h / 10;
        hd = a < b ? a : b;
      end else begin
        d  = w * 900;
        hd = (h > d ? h - d : d - h) / 10;
      end
      cos_hd = sine_q15(hd * 10 + 900);
      case (rq.wanted)
        HEAD_0:   term = sine_q15(h);
        HEAD_90:  term = -sine_q15(h + 900);
        HEAD_180: term = -sine_q15(h);
        default:  term = sine_q15(h + 900);
      endcase
      head = round_q(term * kh, 7);
      want.driving    = 1'b1;
      want.right_duty = wheel_duty(rq.right, cos_hd, head, prev_right);
      want.left_duty  = wheel_duty(rq.left, cos_hd, -head, prev_left);
    end else begin
      // blocked: report walls, stored errors go back to the goal
      want.front_wall = 1'b1;
      want.right_wall = rq.right < side_wall;
      want.left_wall  = rq.left < side_wall;
      prev_right = longint'(goal) <<< 8;
      prev_left  = longint'(goal) <<< 8;
    end
    awaited.push_back(want);
  endfunction

  function void compare_field(string name, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(wcs_pkg::result_t got);
    wcs_pkg::result_t want;
    if (awaited.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    compared++;
    compare_field("driving", want.driving, got.driving);
    compare_field("left_duty", want.left_duty, got.left_duty);
    compare_field("right_duty", want.right_duty, got.right_duty);
    compare_field("front_wall", want.front_wall, got.front_wall);
    compare_field("right_wall", want.right_wall, got.right_wall);
    compare_field("left_wall", want.left_wall, got.left_wall);
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module testbench;
  import wcs_pkg::*;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         LONG_HOLD   = 300;
  localparam logic [2:0] REG_UNUSED  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] front_range = '0;
  logic [11:0] right_range = '0;
  logic [11:0] left_range = '0;
  logic [11:0] measured_heading = '0;
  logic [1:0]  wanted_heading = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        driving;
  logic [6:0]  left_duty;
  logic [6:0]  right_duty;
  logic        front_wall;
  logic        right_wall;
  logic        left_wall;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  steering_scoreboard board;
  int cycle_count = 0;
  int requests_sent = 0;
  int rx_mode = 0;
  int rx_left = 0;
  bit long_hold = 1'b0;

  wall_centering_pd_steering uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[wall_centering_pd_steering] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result({driving, left_duty, right_duty, front_wall, right_wall, left_wall});
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 150);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_left % 4 == 0);
      endcase
    end
  end

  function automatic steer_request_t make_request(int f, int r, int l, int h, cardinal_t w);
    steer_request_t rq;
    rq.front   = 12'(f);
    rq.right   = 12'(r);
    rq.left    = 12'(l);
    rq.heading = 12'(h);
    rq.wanted  = w;
    return rq;
  endfunction

  // mostly within the PD band of the goal, some near the wall threshold
  function automatic logic [11:0] side_range();
    int sel, s;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 12'($urandom_range(0, 2 * board.goal + 2));
    if (sel < 75) begin
      s = board.side_wall;
      s = s + int'($urandom_range(0, 6)) - 3;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return 12'(s);
    end
    return 12'($urandom);
  endfunction

  function automatic steer_request_t random_request();
    steer_request_t rq;
    int sel, centre;
    sel = $urandom_range(0, 99);
    if (sel < 70 && board.front_clear < 12'hFFF)
      rq.front = 12'($urandom_range(board.front_clear + 1, 4095));
    else if (sel < 85)
      rq.front = 12'($urandom_range(0, board.front_clear));
    else
      rq.front = 12'($urandom);
    rq.right  = side_range();
    rq.left   = side_range();
    rq.wanted = 2'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      centre = int'(rq.wanted) * 900;
      rq.heading = 12'((centre + int'($urandom_range(0, 600)) + 3300) % 3600);
    end else if (sel < 90) begin
      rq.heading = 12'($urandom_range(0, 3599));
    end else begin
      rq.heading = 12'($urandom_range(3600, 4095));
    end
    return rq;
  endfunction

  // returns at the accepting edge with in_valid still high
  task automatic push_request(input steer_request_t rq);
    in_valid         <= 1'b1;
    front_range      <= rq.front;
    right_range      <= rq.right;
    left_range       <= rq.left;
    measured_heading <= rq.heading;
    wanted_heading   <= rq.wanted;
    do @(posedge clk); while (!in_ready);
    board.note_request(rq);
    requests_sent++;
  endtask

  task automatic drain();
    if (board.pending() != 0) begin
      in_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clk);
    end
  endtask

  task automatic drive_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic configure(input int ph);
    logic [7:0]  goal_v;
    logic [6:0]  base_v;
    logic [15:0] kp_v, kd_v, kh_v;
    logic [11:0] front_v, side_v;
    goal_v  = 8'($urandom);
    base_v  = 7'($urandom);
    front_v = 12'($urandom_range(0, 1000));
    side_v  = 12'($urandom);
    if (ph % 2 == 1) begin
      kp_v = 16'($urandom);
      kd_v = 16'($urandom);
      kh_v = 16'($urandom);
    end else begin
      kp_v = 16'(int'($urandom_range(0, 1200)) - 600);
      kd_v = 16'(int'($urandom_range(0, 1200)) - 600);
      kh_v = 16'(int'($urandom_range(0, 12000)) - 6000);
    end
    case (ph)
      0: begin
        goal_v = 8'd255; base_v = 7'd100; kp_v = 16'h7FFF; kd_v = 16'h8000;
        kh_v = 16'h7FFF; front_v = 12'd0; side_v = 12'hFFF;
      end
      1: begin
        goal_v = 8'd0; base_v = 7'd0; kp_v = 16'h8000; kd_v = 16'h7FFF;
        kh_v = 16'h8000; front_v = 12'hFFF; side_v = 12'd0;
      end
      2: begin
        goal_v = 8'd50; base_v = 7'd40; front_v = 12'd100; side_v = 12'd120;
      end
      3: begin
        // duty base above the limit, no gains
        goal_v = 8'd1; base_v = 7'd127; kp_v = '0; kd_v = '0;
        kh_v = '0; front_v = 12'd4094; side_v = 12'd1;
      end
      default: ;
    endcase
    drive_reg(REG_UNUSED, 16'($urandom));
    drive_reg(REG_GOAL, {8'($urandom), goal_v});
    drive_reg(REG_BASE, {9'($urandom), base_v});
    drive_reg(REG_KP, kp_v);
    drive_reg(REG_KD, kd_v);
    drive_reg(REG_KH, kh_v);
    drive_reg(REG_FRONT, {4'($urandom), front_v});
    drive_reg(REG_SIDE, {4'($urandom), side_v});
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int ph, input int count);
    int burst_left, gap;
    burst_left = $urandom_range(1, 30);
    for (int i = 0; i < count; i++) begin
      if (ph == 2 && i == 20) begin
        // stop the receiver and keep offering back to back
        long_hold = 1'b1;
        burst_left = 16;
      end
      if (ph % 2 == 1 && i == count / 2) drain();
      push_request(random_request());
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 25);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: blocked and clear fronts, every wanted heading, far walls, wraps
    push_request(make_request(0, 0, 4095, 0, HEAD_0));
    push_request(make_request(80, 99, 100, 900, HEAD_90));
    push_request(make_request(81, 42, 42, 0, HEAD_0));
    push_request(make_request(4095, 84, 85, 0, HEAD_0));
    push_request(make_request(4095, 0, 0, 900, HEAD_90));
    push_request(make_request(4095, 30, 60, 1800, HEAD_180));
    push_request(make_request(4095, 60, 30, 2700, HEAD_270));
    push_request(make_request(4095, 42, 42, 1800, HEAD_0));
    push_request(make_request(4095, 42, 42, 3599, HEAD_0));
    push_request(make_request(4095, 42, 42, 3600, HEAD_0));
    push_request(make_request(4095, 42, 42, 4095, HEAD_270));
    push_request(make_request(4095, 4095, 4095, 4095, HEAD_180));
    push_request(make_request(4095, 20, 70, 950, HEAD_90));
    push_request(make_request(4095, 70, 20, 850, HEAD_90));
    push_request(make_request(4095, 10, 80, 2650, HEAD_270));
    push_request(make_request(4095, 84, 84, 0, HEAD_180));
    push_request(make_request(100, 40, 44, 2000, HEAD_180));
    push_request(make_request(50, 150, 50, 300, HEAD_270));
    push_request(make_request(200, 40, 44, 2000, HEAD_180));
    push_request(make_request(2048, 1365, 2730, 1365, HEAD_90));
    push_request(make_request(1365, 2730, 1365, 2730, HEAD_0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      configure(ph);
      run_phase(ph, ph == 1 ? 40 : 137);
    end

    repeat (40) @(posedge clk);
    $display("%0d steering requests over the reset and 8 further register settings,",
             requests_sent);
    $display("%0d results compared, %0d mismatches, one long output stall",
             board.compared, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[wall_centering_pd_steering] OK");
    end else begin
      $display("[wall_centering_pd_steering] ERROR");
    end
    $finish;
  end

endmodule
